/* rtl/dri_pkg.sv */
// Shared types and constants of the dual range interlock.
package dri_pkg;

   localparam int DistWidth = 16;
   localparam int AgeWidth  = 17;
   localparam int CsrAddrWidth = 4;
   localparam int CsrDataWidth = 32;

   localparam logic [AgeWidth-1:0]  AgeMax          = '1;
   localparam logic [DistWidth-1:0] NearLimitReset  = 16'd235;
   localparam logic [DistWidth-1:0] WindowLowReset  = 16'd170;
   localparam logic [DistWidth-1:0] WindowHighReset = 16'd190;
   localparam logic [DistWidth-1:0] TimeoutReset    = 16'd1500;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_RESET  = 3'd3,
      CMD_SAMPLE = 3'd4,
      CMD_EVAL   = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_RUNNING = 2'd1,
      MODE_UNSAFE  = 2'd2,
      MODE_STOPPED = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      MSG_STARTED = 3'd0,
      MSG_STOPPED = 3'd1,
      MSG_RESET   = 3'd2,
      MSG_FAILED  = 3'd3,
      MSG_PASSED  = 3'd4,
      MSG_WAITING = 3'd5,
      MSG_NONE    = 3'd6
   } message_type;

   typedef enum logic [1:0] {
      OC_NONE   = 2'd0,
      OC_PASSED = 2'd1,
      OC_FAILED = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      CSR_NEAR_LIMIT  = 2'd0,
      CSR_WINDOW_LOW  = 2'd1,
      CSR_WINDOW_HIGH = 2'd2,
      CSR_TIMEOUT     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DistWidth-1:0] near_limit_one;
      logic [DistWidth-1:0] window_low_two;
      logic [DistWidth-1:0] window_high_two;
      logic [DistWidth-1:0] stale_timeout;
   } cfg_type;

   typedef struct packed {
      command_type          command;
      logic                 sensor_select;
      logic [DistWidth-1:0] distance_cm;
      logic                 sample_valid;
   } req_item_type;

   typedef struct packed {
      mode_type    block_state;
      message_type status_message;
      logic        state_changed;
      logic        one_usable;
      logic        two_usable;
      logic        range_passed;
      logic        all_passed;
      logic        fail_reason;
      logic        pass_event;
      logic        fail_event;
   } rsp_item_type;

endpackage

/* rtl/dri_csr.sv */
// Configuration registers of the dual range interlock with their APB-style access port.
module dri_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dri_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [dri_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [dri_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready,
   output dri_pkg::cfg_type                 cfg
);
   import dri_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;
   logic [DistWidth-1:0] read_value;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[CsrAddrWidth-1:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_NEAR_LIMIT:  cfg_in.near_limit_one  = csr_pwdata[DistWidth-1:0];
            CSR_WINDOW_LOW:  cfg_in.window_low_two  = csr_pwdata[DistWidth-1:0];
            CSR_WINDOW_HIGH: cfg_in.window_high_two = csr_pwdata[DistWidth-1:0];
            CSR_TIMEOUT:     cfg_in.stale_timeout   = csr_pwdata[DistWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_NEAR_LIMIT:  read_value = cfg_ff.near_limit_one;
         CSR_WINDOW_LOW:  read_value = cfg_ff.window_low_two;
         CSR_WINDOW_HIGH: read_value = cfg_ff.window_high_two;
         CSR_TIMEOUT:     read_value = cfg_ff.stale_timeout;
         default:         read_value = '0;
      endcase
   end

   assign csr_prdata = {{(CsrDataWidth-DistWidth){1'b0}}, read_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_limit_one  <= NearLimitReset;
         cfg_ff.window_low_two  <= WindowLowReset;
         cfg_ff.window_high_two <= WindowHighReset;
         cfg_ff.stale_timeout   <= TimeoutReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/dri_in_reg.sv */
// Input register stage that holds one accepted command transaction.
module dri_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  dri_pkg::req_item_type in_item,
   output logic                  in_ready,
   input  logic                  advance,
   output logic                  item_valid,
   output dri_pkg::req_item_type item
);
   import dri_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/dri_core.sv */
// Interlock state and the single-pass command, staleness and range check logic.
module dri_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  dri_pkg::req_item_type item,
   input  dri_pkg::cfg_type      cfg,
   output dri_pkg::rsp_item_type result
);
   import dri_pkg::*;

   logic                 run_ff, run_in;
   logic                 tbo_ff, tbo_in;
   outcome_type          outcome_ff, outcome_in;
   mode_type             mode_ff, mode_in;
   message_type          msg_ff, msg_in;
   logic [DistWidth-1:0] dist_ff [2];
   logic [DistWidth-1:0] dist_in [2];
   logic                 rok_ff [2];
   logic                 rok_in [2];
   logic                 stamp_ff [2];
   logic                 stamp_in [2];
   logic [AgeWidth-1:0]  age_ff [2];
   logic [AgeWidth-1:0]  age_in [2];
   logic                 vrange_ff, vrange_in;
   logic                 vall_ff, vall_in;
   logic                 vfail_ff, vfail_in;

   always_comb begin
      logic do_check;
      logic clear;
      logic chg;
      logic evp;
      logic evf;
      logic p1;
      logic p2;
      logic rp;
      mode_type    new_mode;
      message_type new_msg;
      outcome_type new_oc;
      logic        set_mm;
      logic        set_oc;

      run_in     = run_ff;
      tbo_in     = tbo_ff;
      outcome_in = outcome_ff;
      mode_in    = mode_ff;
      msg_in     = msg_ff;
      vrange_in  = vrange_ff;
      vall_in    = vall_ff;
      vfail_in   = vfail_ff;
      for (int i = 0; i < 2; i++) begin
         dist_in[i]  = dist_ff[i];
         rok_in[i]   = rok_ff[i];
         stamp_in[i] = stamp_ff[i];
         age_in[i]   = age_ff[i];
      end
      do_check = 1'b0;
      clear    = 1'b0;
      chg      = 1'b0;
      evp      = 1'b0;
      evf      = 1'b0;
      p1       = 1'b0;
      p2       = 1'b0;
      rp       = 1'b0;
      set_mm   = 1'b0;
      set_oc   = 1'b0;
      new_mode = mode_ff;
      new_msg  = msg_ff;
      new_oc   = outcome_ff;

      case (item.command)
         CMD_TICK: begin
            if (tbo_ff) begin
               for (int i = 0; i < 2; i++) begin
                  if (stamp_ff[i] && age_ff[i] != AgeMax) begin
                     age_in[i] = age_ff[i] + AgeWidth'(1);
                  end
               end
            end
         end
         CMD_START: begin
            tbo_in   = 1'b1;
            clear    = 1'b1;
            run_in   = 1'b1;
            mode_in  = MODE_RUNNING;
            msg_in   = MSG_STARTED;
            chg      = 1'b1;
            do_check = 1'b1;
         end
         CMD_STOP: begin
            if (run_ff || mode_ff != MODE_STOPPED) begin
               run_in     = 1'b0;
               outcome_in = OC_NONE;
               if (mode_ff != MODE_STOPPED || msg_ff != MSG_STOPPED) begin
                  chg = 1'b1;
               end
               mode_in = MODE_STOPPED;
               msg_in  = MSG_STOPPED;
            end
         end
         CMD_RESET: begin
            clear = 1'b1;
            if (run_ff) begin
               if (mode_ff != MODE_RUNNING || msg_ff != MSG_RESET) begin
                  chg = 1'b1;
               end
               mode_in = MODE_RUNNING;
               msg_in  = MSG_RESET;
            end else begin
               if (mode_ff != MODE_IDLE) begin
                  chg = 1'b1;
               end
               mode_in = MODE_IDLE;
            end
         end
         CMD_SAMPLE: begin
            dist_in[item.sensor_select]  = item.distance_cm;
            rok_in[item.sensor_select]   = item.sample_valid;
            stamp_in[item.sensor_select] = tbo_ff;
            age_in[item.sensor_select]   = '0;
            do_check = run_ff;
         end
         CMD_EVAL: begin
            do_check = 1'b1;
         end
         default: begin
            do_check = 1'b0;
         end
      endcase

      if (clear) begin
         for (int i = 0; i < 2; i++) begin
            dist_in[i]  = '0;
            rok_in[i]   = 1'b0;
            stamp_in[i] = 1'b0;
            age_in[i]   = '0;
         end
         vrange_in  = 1'b0;
         vall_in    = 1'b0;
         vfail_in   = 1'b0;
         outcome_in = OC_NONE;
      end

      if (do_check) begin
         if (tbo_in) begin
            for (int i = 0; i < 2; i++) begin
               if (rok_in[i] &&
                   (!stamp_in[i] || age_in[i] > {1'b0, cfg.stale_timeout})) begin
                  rok_in[i] = 1'b0;
               end
            end
         end
         p1 = rok_in[0] && (dist_in[0] > cfg.near_limit_one);
         p2 = rok_in[1] && (dist_in[1] >= cfg.window_low_two) &&
              (dist_in[1] <= cfg.window_high_two);
         rp = p1 && p2;
         vrange_in = rp;
         vall_in   = rp;
         vfail_in  = 1'b0;
         if (run_in) begin
            if (outcome_in == OC_PASSED) begin
               vall_in = 1'b1;
            end else if (rok_in[0] && rok_in[1] && !rp) begin
               vrange_in = 1'b0;
               vall_in   = 1'b0;
               vfail_in  = 1'b1;
               set_mm    = 1'b1;
               new_mode  = MODE_UNSAFE;
               new_msg   = MSG_FAILED;
               set_oc    = 1'b1;
               new_oc    = OC_FAILED;
            end else if (rp) begin
               set_mm   = 1'b1;
               new_mode = MODE_RUNNING;
               new_msg  = MSG_PASSED;
               set_oc   = 1'b1;
               new_oc   = OC_PASSED;
            end else begin
               set_mm   = 1'b1;
               new_mode = MODE_RUNNING;
               new_msg  = MSG_WAITING;
               if (outcome_in == OC_FAILED) begin
                  outcome_in = OC_NONE;
               end
            end
         end
         if (set_mm) begin
            if (mode_in != new_mode || msg_in != new_msg) begin
               chg = 1'b1;
            end
            mode_in = new_mode;
            msg_in  = new_msg;
         end
         if (set_oc && outcome_in != new_oc) begin
            outcome_in = new_oc;
            evp = (new_oc == OC_PASSED);
            evf = (new_oc == OC_FAILED);
         end
      end

      result.block_state    = mode_in;
      result.status_message = msg_in;
      result.state_changed  = chg;
      result.one_usable     = rok_in[0];
      result.two_usable     = rok_in[1];
      result.range_passed   = vrange_in;
      result.all_passed     = vall_in;
      result.fail_reason    = vfail_in;
      result.pass_event     = evp;
      result.fail_event     = evf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         tbo_ff     <= 1'b0;
         outcome_ff <= OC_NONE;
         mode_ff    <= MODE_IDLE;
         msg_ff     <= MSG_NONE;
         vrange_ff  <= 1'b0;
         vall_ff    <= 1'b0;
         vfail_ff   <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            dist_ff[i]  <= '0;
            rok_ff[i]   <= 1'b0;
            stamp_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else if (fire) begin
         run_ff     <= run_in;
         tbo_ff     <= tbo_in;
         outcome_ff <= outcome_in;
         mode_ff    <= mode_in;
         msg_ff     <= msg_in;
         vrange_ff  <= vrange_in;
         vall_ff    <= vall_in;
         vfail_ff   <= vfail_in;
         for (int i = 0; i < 2; i++) begin
            dist_ff[i]  <= dist_in[i];
            rok_ff[i]   <= rok_in[i];
            stamp_ff[i] <= stamp_in[i];
            age_ff[i]   <= age_in[i];
         end
      end
   end

endmodule

/* rtl/dual_range_interlock.sv */
// Top level of the dual range interlock: input stage, check logic, result register, CSRs.
//
// Every command transaction yields exactly one result transaction. A command is held in
// the input register, is evaluated against the sensor state in a single pass of compare
// logic, and its result is held in the output register until taken; a new command is
// accepted every cycle while no result waits or the waiting result is taken, and one
// more is taken while a result waits. Registers: 0x0 near limit of sensor one, 0x4 low
// and 0x8 high window bound of sensor two, 0xC staleness timeout in ticks; write them
// only while no transaction is in flight.
module dual_range_interlock (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // distance_cm
   input  logic [4:0]  req_tuser,   // command[2:0], sensor_select[3], sample_valid[4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // block_state[1:0], status_message[4:2], state_changed[5], one_usable[6],
   // two_usable[7], range_passed[8], all_passed[9], fail_reason[10],
   // pass_event[11], fail_event[12], zero[15:13]
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dri_pkg::*;

   cfg_type      cfg;
   req_item_type in_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         item_valid;
   logic         advance;
   logic         fire;

   assign in_item.command       = command_type'(req_tuser[2:0]);
   assign in_item.sensor_select = req_tuser[3];
   assign in_item.sample_valid  = req_tuser[4];
   assign in_item.distance_cm   = req_tdata;

   dri_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dri_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_item    (in_item),
      .in_ready   (req_tready),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = item_valid && advance;

   dri_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.fail_event,
                        rsp_ff.pass_event,
                        rsp_ff.fail_reason,
                        rsp_ff.all_passed,
                        rsp_ff.range_passed,
                        rsp_ff.two_usable,
                        rsp_ff.one_usable,
                        rsp_ff.state_changed,
                        rsp_ff.status_message,
                        rsp_ff.block_state};

endmodule
